// ===== src/awrp_pkg.sv =====
// ----------------------------------------------------------------------------
// awrp_pkg
// Shared types and codes of the age weighted roulette picker: request and
// response words, request codes and status codes.
// ----------------------------------------------------------------------------
package awrp_pkg;

	localparam int ID_W      = 16;
	localparam int STAMP_W   = 32;
	localparam int FRAC_W    = 16;
	localparam int ENTRIES_W = 7;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_APPEND = 2'd1;
	localparam logic [1:0] REQ_DRAW   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [ID_W-1:0]    entry_id;
		logic [STAMP_W-1:0] last_used;
		logic [FRAC_W-1:0]  random_fraction;
	} req_word_t;

	typedef struct packed {
		logic [ID_W-1:0]      picked_id;
		logic [1:0]           status;
		logic [ENTRIES_W-1:0] entries_left;
	} rsp_word_t;

endpackage

// ===== src/age_weighted_roulette_picker_unit.sv =====
// ----------------------------------------------------------------------------
// age_weighted_roulette_picker_unit
// List of id/weight entries with weight floor(2^WFB/(age+1)); draws one
// entry by roulette selection over the running prefix and removes it.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              word
//  req      in   req_valid/req_ready    awrp_pkg::req_word_t
//  rsp      out  rsp_valid/rsp_ready    awrp_pkg::rsp_word_t
//  cfg      in   cfg_wr_en              current_cycle, 32 bits
//
// clear and unused codes go straight to the response state, an append waits
// on the reciprocal unit (it resolves one quotient bit a cycle), and a draw
// walks the list: the list memory gives one read a cycle for the
// prefix walk and then for closing the gap. One request is worked at a time;
// a finished word waits in the output register while the next request is
// taken. Reset clears count, total and current_cycle; the list memory is not
// cleared, only entries below the count are read.
// ----------------------------------------------------------------------------
module age_weighted_roulette_picker_unit #(
	parameter int MAX_ENTRIES      = 64,
	parameter int WEIGHT_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  awrp_pkg::req_word_t   req_word,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output awrp_pkg::rsp_word_t   rsp_word,
	input  logic                  cfg_wr_en,
	input  logic [31:0]           cfg_wr_data
);

	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam int WW = WEIGHT_FRAC_BITS + 1;
	localparam int TW = WW + IW;
	localparam int SW = TW + awrp_pkg::FRAC_W;
	localparam int EW = awrp_pkg::ID_W + WW;
	localparam int DW = awrp_pkg::STAMP_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APP_DIV,
		ST_SCAN,
		ST_SHIFT,
		ST_RESP
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 cnt_q;
	logic [TW-1:0]                 tot_q;
	logic [awrp_pkg::STAMP_W-1:0]  cur_cycle_q;
	logic                          rsp_valid_q;
	awrp_pkg::rsp_word_t           rsp_q;
	logic [awrp_pkg::ID_W-1:0]     pick_id_q;
	logic [1:0]                    status_q;
	logic [awrp_pkg::ID_W-1:0]     id_q;
	logic [SW-1:0]                 scaled_q;
	logic [TW-1:0]                 prefix_q;
	logic [CW-1:0]                 idx_q;
	logic [CW-1:0]                 src_q;
	logic                          scan_vld_s1;
	logic [IW-1:0]                 scan_idx_s1;
	logic                          shf_vld_s1;
	logic [IW-1:0]                 shf_dst_s1;

	logic [EW-1:0]                 mem [MAX_ENTRIES];
	logic [EW-1:0]                 mem_rd_q;
	logic [IW-1:0]                 rd_addr;
	logic                          mem_we;
	logic [IW-1:0]                 mem_wa;
	logic [EW-1:0]                 mem_wd;

	logic                          req_fire;
	logic                          div_start;
	logic [DW-1:0]                 div_divisor;
	logic                          div_done;
	logic [WW-1:0]                 div_quot;

	logic [awrp_pkg::ID_W-1:0]     rd_id;
	logic [WW-1:0]                 rd_w;
	logic [TW-1:0]                 psum;
	logic                          hit;
	logic                          last;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// age wraps modulo 2^32, the +1 may reach 2^32
	assign div_start   = req_fire && (req_word.req_type == awrp_pkg::REQ_APPEND)
		&& (cnt_q < CW'(MAX_ENTRIES));
	assign div_divisor = {1'b0, cur_cycle_q - req_word.last_used} + DW'(1);

	awrp_recip #(
		.WFB(WEIGHT_FRAC_BITS)
	) u_recip (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.divisor(div_divisor),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		rd_id = mem_rd_q[EW-1 -: awrp_pkg::ID_W];
		rd_w  = mem_rd_q[WW-1:0];
		psum  = prefix_q + TW'(rd_w);
		hit   = ({psum, {awrp_pkg::FRAC_W{1'b0}}} >= scaled_q);
		last  = (CW'(scan_idx_s1) == (cnt_q - CW'(1)));
		rd_addr = (state_q == ST_SHIFT) ? src_q[IW-1:0] : idx_q[IW-1:0];
		mem_we = 1'b0;
		mem_wa = shf_dst_s1;
		mem_wd = mem_rd_q;
		if (state_q == ST_APP_DIV && div_done) begin
			mem_we = 1'b1;
			mem_wa = cnt_q[IW-1:0];
			mem_wd = {id_q, div_quot};
		end else if (state_q == ST_SHIFT && shf_vld_s1) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			tot_q       <= '0;
			cur_cycle_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			pick_id_q   <= '0;
			status_q    <= awrp_pkg::STAT_OK;
			id_q        <= '0;
			scaled_q    <= '0;
			prefix_q    <= '0;
			idx_q       <= '0;
			src_q       <= '0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
			shf_vld_s1  <= 1'b0;
			shf_dst_s1  <= '0;
		end else begin
			if (cfg_wr_en) begin
				cur_cycle_q <= cfg_wr_data;
			end
			// the response state loads the register itself
			if (rsp_valid_q && rsp_ready && state_q != ST_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						pick_id_q   <= '0;
						status_q    <= awrp_pkg::STAT_OK;
						id_q        <= req_word.entry_id;
						prefix_q    <= '0;
						idx_q       <= '0;
						scan_vld_s1 <= 1'b0;
						shf_vld_s1  <= 1'b0;
						scaled_q    <= SW'(req_word.random_fraction) * SW'(tot_q);
						state_q     <= ST_RESP;
						case (req_word.req_type)
							awrp_pkg::REQ_CLEAR: begin
								cnt_q <= '0;
								tot_q <= '0;
							end
							awrp_pkg::REQ_APPEND: begin
								if (cnt_q >= CW'(MAX_ENTRIES)) begin
									status_q <= awrp_pkg::STAT_FULL;
								end else begin
									state_q <= ST_APP_DIV;
								end
							end
							awrp_pkg::REQ_DRAW: begin
								if (cnt_q == '0) begin
									status_q <= awrp_pkg::STAT_EMPTY;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_APP_DIV: begin
					if (div_done) begin
						tot_q   <= tot_q + TW'(div_quot);
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_RESP;
					end
				end
				ST_SCAN: begin
					// one read issued a cycle, checked in the cycle after
					if (idx_q < cnt_q) begin
						scan_vld_s1 <= 1'b1;
						scan_idx_s1 <= idx_q[IW-1:0];
						idx_q       <= idx_q + CW'(1);
					end else begin
						scan_vld_s1 <= 1'b0;
					end
					if (scan_vld_s1) begin
						if (hit || last) begin
							pick_id_q  <= rd_id;
							tot_q      <= tot_q - TW'(rd_w);
							cnt_q      <= cnt_q - CW'(1);
							src_q      <= CW'(scan_idx_s1) + CW'(1);
							shf_vld_s1 <= 1'b0;
							state_q    <= ST_SHIFT;
						end else begin
							prefix_q <= psum;
						end
					end
				end
				ST_SHIFT: begin
					// move each later entry down one place
					if (src_q <= cnt_q) begin
						shf_vld_s1 <= 1'b1;
						shf_dst_s1 <= IW'(src_q - CW'(1));
						src_q      <= src_q + CW'(1);
					end else begin
						shf_vld_s1 <= 1'b0;
						if (!shf_vld_s1) begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q        <= 1'b1;
						rsp_q.picked_id    <= pick_id_q;
						rsp_q.status       <= status_q;
						rsp_q.entries_left <= awrp_pkg::ENTRIES_W'(cnt_q);
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_in_append: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_APP_DIV))
		else $error("reciprocal finished outside an append");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_ENTRIES))
		else $error("entry count above list size");

	a_empty_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (tot_q == '0))
		else $error("empty list with non-zero total");

	a_scan_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && scan_vld_s1) |-> (CW'(scan_idx_s1) < cnt_q))
		else $error("prefix walk read past the list");

endmodule

// ===== src/awrp_recip.sv =====
// ----------------------------------------------------------------------------
// awrp_recip
// Restoring divider for floor(2^WFB / divisor), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module awrp_recip #(
	parameter int WFB = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [awrp_pkg::STAMP_W:0]    divisor,
	output logic                          done,
	output logic [WFB:0]                  quot
);

	localparam int WW = WFB + 1;
	localparam int BW = $clog2(WW);
	localparam int DW = awrp_pkg::STAMP_W + 1;

	logic          busy_q;
	logic          done_q;
	logic [BW-1:0] bit_q;
	logic [DW-1:0] div_q;
	logic [DW-1:0] rem_q;
	logic [WW-1:0] quo_q;

	logic [DW:0]   sh;
	logic [DW:0]   diff;
	logic          ge;

	// dividend is a single one at the top bit
	always_comb begin
		sh   = {rem_q, (bit_q == BW'(WFB))};
		diff = sh - {1'b0, div_q};
		ge   = (sh >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BW'(WFB);
			end else if (busy_q) begin
				if (bit_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					bit_q <= bit_q - BW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
			quo_q <= {quo_q[WW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the age weighted roulette picker. A queue of
// requests feeds a valid/ready driver; an internal list predictor works out
// the expected response word of every accepted request, and a monitor checks
// each response word field by field. Phases change current_cycle and the
// amount of idling on both channels.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIST_DEPTH  = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int N_PHASES    = 9;
	localparam int PHASE_ITEMS = 90;

	// request code with no meaning, must leave the list alone
	localparam logic [1:0] REQ_SPARE = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	awrp_pkg::req_word_t   req_word;
	logic                  rsp_valid;
	logic                  rsp_ready;
	awrp_pkg::rsp_word_t   rsp_word;
	logic                  cfg_wr_en;
	logic [31:0]           cfg_wr_data;

	// predictor state
	logic [awrp_pkg::ID_W-1:0]    list_id [LIST_DEPTH];
	logic [16:0]                  list_weight [LIST_DEPTH];
	int unsigned                  list_count;
	logic [22:0]                  list_total;
	logic [awrp_pkg::STAMP_W-1:0] cycle_now;

	awrp_pkg::req_word_t pending_reqs[$];
	awrp_pkg::rsp_word_t expected_rsps[$];
	int unsigned reqs_queued;
	int unsigned reqs_taken;
	logic        req_taken;
	int          send_idle_pct;
	int          recv_stall_pct;

	// stimulus planning
	int unsigned                  plan_count;
	logic [awrp_pkg::STAMP_W-1:0] plan_cycle;

	int unsigned cycle_count;
	int unsigned mismatches;
	int unsigned words_checked;
	int unsigned draws_done;
	int unsigned full_appends;
	int unsigned empty_draws;

	age_weighted_roulette_picker_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_word    (req_word),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp_word    (rsp_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic awrp_pkg::rsp_word_t roulette_predict(input awrp_pkg::req_word_t rq);
		awrp_pkg::rsp_word_t          rs;
		logic [awrp_pkg::STAMP_W-1:0] age;
		logic [32:0]                  denom;
		logic [39:0]                  scaled;
		logic [22:0]                  prefix;
		int unsigned                  hit;
		bit                           found;
		rs = '0;
		if (rq.req_type == awrp_pkg::REQ_CLEAR) begin
			list_count = 0;
			list_total = '0;
		end else if (rq.req_type == awrp_pkg::REQ_APPEND) begin
			if (list_count >= LIST_DEPTH) begin
				rs.status = awrp_pkg::STAT_FULL;
				full_appends++;
			end else begin
				age = cycle_now - rq.last_used;
				denom = {1'b0, age} + 33'd1;
				list_id[list_count] = rq.entry_id;
				list_weight[list_count] = 17'(33'h1_0000 / denom);
				list_total = list_total + 23'(list_weight[list_count]);
				list_count++;
			end
		end else if (rq.req_type == awrp_pkg::REQ_DRAW) begin
			if (list_count == 0) begin
				rs.status = awrp_pkg::STAT_EMPTY;
				empty_draws++;
			end else begin
				scaled = 40'(rq.random_fraction) * 40'(list_total);
				prefix = '0;
				hit = list_count - 1;
				found = 1'b0;
				for (int k = 0; k < list_count; k++) begin
					prefix = prefix + 23'(list_weight[k]);
					if (!found && {prefix, 16'h0} >= scaled) begin
						hit = k;
						found = 1'b1;
					end
				end
				rs.picked_id = list_id[hit];
				list_total = list_total - 23'(list_weight[hit]);
				list_count--;
				// close the gap left by the picked entry
				for (int j = hit; j < list_count; j++) begin
					list_id[j] = list_id[j+1];
					list_weight[j] = list_weight[j+1];
				end
				draws_done++;
			end
		end
		rs.entries_left = awrp_pkg::ENTRIES_W'(list_count);
		return rs;
	endfunction

	// driver: inputs move on the falling edge
	always @(negedge clk) begin
		if (!req_valid || req_taken) begin
			if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_word <= pending_reqs.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// monitor and predictor: everything sampled on the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (cfg_wr_en)
			cycle_now = cfg_wr_data;
		req_taken <= req_valid && req_ready;
		if (req_valid && req_ready) begin
			expected_rsps.push_back(roulette_predict(req_word));
			reqs_taken++;
		end
		if (rsp_valid && rsp_ready) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected word id %h status %0d left %0d",
						rsp_word.picked_id, rsp_word.status, rsp_word.entries_left);
			end else begin
				awrp_pkg::rsp_word_t exp_w;
				exp_w = expected_rsps.pop_front();
				words_checked++;
				if (rsp_word.picked_id !== exp_w.picked_id || rsp_word.status !== exp_w.status ||
						rsp_word.entries_left !== exp_w.entries_left) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: word %0d: id %h/%h status %0d/%0d left %0d/%0d (exp/got)",
							words_checked, exp_w.picked_id, rsp_word.picked_id,
							exp_w.status, rsp_word.status,
							exp_w.entries_left, rsp_word.entries_left);
				end
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: timed out after %0d cycles", cycle_count);
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic push_req(input logic [1:0] kind, input logic [awrp_pkg::ID_W-1:0] id,
			input logic [awrp_pkg::STAMP_W-1:0] stamp,
			input logic [awrp_pkg::FRAC_W-1:0] frac);
		awrp_pkg::req_word_t w;
		w.req_type = kind;
		w.entry_id = id;
		w.last_used = stamp;
		w.random_fraction = frac;
		pending_reqs.push_back(w);
		reqs_queued++;
		if (kind == awrp_pkg::REQ_CLEAR)
			plan_count = 0;
		else if (kind == awrp_pkg::REQ_APPEND && plan_count < LIST_DEPTH)
			plan_count++;
		else if (kind == awrp_pkg::REQ_DRAW && plan_count > 0)
			plan_count--;
	endtask

	function automatic logic [awrp_pkg::STAMP_W-1:0] random_stamp();
		int          sel;
		logic [31:0] age;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			age = $urandom_range(0, 15);
		else if (sel < 7)
			age = $urandom_range(0, 65535);
		else if (sel < 8)
			age = 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			return $urandom();
		return plan_cycle - age;
	endfunction

	function automatic logic [awrp_pkg::FRAC_W-1:0] random_frac();
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return 16'($urandom_range(0, 65535));
	endfunction

	task automatic push_append();
		push_req(awrp_pkg::REQ_APPEND, 16'($urandom_range(0, 65535)), random_stamp(),
			16'($urandom_range(0, 65535)));
	endtask

	task automatic push_draw();
		push_req(awrp_pkg::REQ_DRAW, 16'($urandom_range(0, 65535)), $urandom(),
			random_frac());
	endtask

	task automatic queue_random_traffic(input int n_items);
		int made;
		int pick;
		made = 0;
		while (made < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 4) begin
				// fill the list, knock on it while full, then take some back
				while (plan_count < LIST_DEPTH) begin
					push_append();
					made++;
				end
				repeat ($urandom_range(1, 3)) begin
					push_append();
					made++;
				end
				repeat ($urandom_range(1, LIST_DEPTH)) begin
					push_draw();
					made++;
				end
			end else if (pick < 55) begin
				repeat ($urandom_range(1, 8)) begin
					push_append();
					made++;
				end
				repeat ($urandom_range(1, plan_count)) begin
					push_draw();
					made++;
				end
			end else if (pick < 62) begin
				push_req(awrp_pkg::REQ_CLEAR, 16'($urandom_range(0, 65535)), $urandom(),
					16'($urandom_range(0, 65535)));
				made++;
			end else if (pick < 67) begin
				// unused code, leaves the list alone
				push_req(REQ_SPARE, 16'($urandom_range(0, 65535)), $urandom(),
					16'($urandom_range(0, 65535)));
				made++;
			end else begin
				push_draw();
				made++;
			end
		end
	endtask

	task automatic write_cycle(input logic [31:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		plan_cycle = value;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (reqs_taken != reqs_queued || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	task automatic set_idle(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SEND) ? 75 : (mode == IDLE_BOTH) ? 23 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 75 : (mode == IDLE_BOTH) ? 23 : 0;
	endtask

	initial begin
		logic [31:0] phase_cycle [N_PHASES];
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_word = '0;
		rsp_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_taken = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		list_count = 0;
		list_total = '0;
		cycle_now = '0;
		plan_count = 0;
		plan_cycle = '0;
		reqs_queued = 0;
		reqs_taken = 0;
		cycle_count = 0;
		mismatches = 0;
		words_checked = 0;
		draws_done = 0;
		full_appends = 0;
		empty_draws = 0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			list_id[i] = '0;
			list_weight[i] = '0;
		end
		phase_cycle[0] = 32'd0;
		phase_cycle[1] = 32'hFFFF_FFFF;
		phase_cycle[2] = $urandom();
		phase_cycle[3] = 32'h8000_0000;
		phase_cycle[4] = 32'd5;
		phase_cycle[5] = $urandom();
		phase_cycle[6] = 32'h0001_0000;
		phase_cycle[7] = $urandom();
		phase_cycle[8] = 32'h7FFF_FFFF;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: edge cases of the list at current_cycle 100
		write_cycle(32'd100);
		@(posedge clk);
		set_idle(IDLE_NONE);
		push_req(awrp_pkg::REQ_DRAW, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(REQ_SPARE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(awrp_pkg::REQ_APPEND, 16'hFFFF, 32'd100, 16'h0000);
		push_req(awrp_pkg::REQ_APPEND, 16'h0000, 32'd101, 16'hFFFF);
		push_req(awrp_pkg::REQ_APPEND, 16'h1234, 32'd99, 16'h0000);
		push_req(awrp_pkg::REQ_APPEND, 16'hABCD, 32'd0, 16'h0000);
		push_req(REQ_SPARE, 16'h0000, 32'h0000_0000, 16'h0000);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'h0000);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'hFFFF);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'h8000);
		push_req(awrp_pkg::REQ_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'h1234);
		push_req(awrp_pkg::REQ_APPEND, 16'h0007, 32'd101, 16'h0000);
		push_req(awrp_pkg::REQ_APPEND, 16'h0008, 32'd102, 16'h0000);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'h8000);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'hFFFF);
		push_req(awrp_pkg::REQ_APPEND, 16'h5555, 32'hFFFF_0064, 16'h0000);
		push_req(awrp_pkg::REQ_APPEND, 16'hAAAA, 32'd36, 16'h0000);
		push_req(awrp_pkg::REQ_DRAW, 16'h0000, 32'h0, 16'hFFFF);
		push_req(awrp_pkg::REQ_CLEAR, 16'h0000, 32'h0, 16'h0000);
		push_req(awrp_pkg::REQ_CLEAR, 16'h0000, 32'h0, 16'h0000);
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			write_cycle(phase_cycle[p]);
			@(posedge clk);
			set_idle(idle_mode_t'(p % 4));
			queue_random_traffic(PHASE_ITEMS);
			wait_drained();
			// no idling between phases
			@(posedge clk);
			set_idle(IDLE_NONE);
		end

		repeat (100) @(posedge clk);
		$display("tb: %0d words checked over %0d phases; %0d draws, %0d on empty list",
			words_checked, N_PHASES + 1, draws_done, empty_draws);
		$display("tb: %0d appends on full list, %0d mismatches", full_appends, mismatches);
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
